/* design/lsf_pkg.sv */
// lsf_pkg: shared types, constants and helpers of the line substring filter
// used by every module of the filter; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

  localparam int PatternMax = 16;
  localparam int LineLimit  = 255;
  localparam int ByteW      = 8;
  localparam int ColW       = 8;
  localparam int LineW      = 16;
  localparam int PatLenW    = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int LenIdxW    = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  localparam logic [ByteW-1:0] Newline   = 8'd10;
  localparam logic [ByteW-1:0] UpperA    = 8'd65;
  localparam logic [ByteW-1:0] UpperZ    = 8'd90;
  localparam logic [ByteW-1:0] CaseDelta = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_PAT_LEN = 3'd2,
    CFG_ICASE   = 3'd3,
    CFG_INVERT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PatternMax-1:0][ByteW-1:0] pattern;
    logic [LenIdxW-1:0]               len_m1;
    logic                             icase;
    logic                             invert;
  } cfg_t;

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic             selected;
    logic             final_line;
  } result_t;

  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] c,
                                                 input logic icase);
    logic [ByteW-1:0] r;
    r = c;
    if (icase && c >= UpperA && c <= UpperZ) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/lsf_match.sv */
// lsf_match: compares the pattern against the newest bytes of the line window
// depends on lsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsf_match import lsf_pkg::*; (
  input  logic [PatternMax-1:0][ByteW-1:0] win_i,
  input  cfg_t                             cfg_i,
  output logic                             hit_o
);

  logic [PatternMax-1:0] eq;

  // pattern byte j lines up with window byte len-1-j (window is newest first)
  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      logic [LenIdxW-1:0] idx;
      logic               active;
      idx    = cfg_i.len_m1 - LenIdxW'(j);
      active = LenIdxW'(j) <= cfg_i.len_m1;
      eq[j]  = !active ||
               (fold_byte(cfg_i.pattern[j], cfg_i.icase) ==
                fold_byte(win_i[idx], cfg_i.icase));
    end
  end

  assign hit_o = &eq;

endmodule

`default_nettype wire

/* design/lsf_line_state.sv */
// lsf_line_state: per-line window, column count, match flag and line counter
// depends on lsf_pkg and lsf_match
`timescale 1ns / 1ps
`default_nettype none

module lsf_line_state import lsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_file_i,
  input  cfg_t             cfg_i,
  output logic             push_o,
  output result_t          result_o
);

  logic [PatternMax-1:0][ByteW-1:0] win_q, win_d;
  logic [ColW-1:0]                  col_q, col_d;
  logic                             match_q, match_d;
  logic [LineW-1:0]                 line_q, line_d;

  logic            is_nl, searchable, finish, hit, hit_ok, match_now;
  logic [ColW-1:0] col_inc;

  assign is_nl      = text_byte_i == Newline;
  assign searchable = !is_nl && (col_q < ColW'(LineLimit));
  assign finish     = is_nl || end_of_file_i;
  assign col_inc    = col_q + ColW'(1);

  // window as it stands once this byte is shifted in
  always_comb begin
    win_d[0] = text_byte_i;
    for (int i = 1; i < PatternMax; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  lsf_match u_match (
    .win_i (win_d),
    .cfg_i (cfg_i),
    .hit_o (hit)
  );

  // only compare once the line holds at least a full pattern
  assign hit_ok    = searchable && (col_inc > ColW'(cfg_i.len_m1)) && hit;
  assign match_now = match_q || hit_ok;

  always_comb begin
    col_d   = col_q;
    match_d = match_q;
    line_d  = line_q;
    if (accept_i) begin
      if (searchable) begin
        col_d   = col_inc;
        match_d = match_now;
      end
      if (finish) begin
        col_d   = '0;
        match_d = 1'b0;
        if (end_of_file_i) begin
          line_d = LineW'(1);
        end else if (line_q != '1) begin
          line_d = line_q + LineW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      col_q   <= '0;
      match_q <= 1'b0;
      line_q  <= LineW'(1);
    end else begin
      if (accept_i && searchable) begin
        win_q <= win_d;
      end
      col_q   <= col_d;
      match_q <= match_d;
      line_q  <= line_d;
    end
  end

  assign push_o               = accept_i && finish;
  assign result_o.line_number = line_q;
  assign result_o.selected    = cfg_i.invert ^ match_now;
  assign result_o.final_line  = end_of_file_i;

endmodule

`default_nettype wire

/* design/lsf_result_queue.sv */
// lsf_result_queue: two-entry result buffer between line logic and output port
// depends on lsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsf_result_queue import lsf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output logic    full_o,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/line_substring_filter_core.sv */
// line_substring_filter_core: fixed-string line filter, one text byte per cycle
// latency: with the queue empty, a result is valid the cycle after its closing beat
// throughput: one byte per clock; a two-entry result queue keeps input open while
// one result waits, so input stalls only when two results are pending
// reset: config returns to pattern 0, length 1, options off; line number to 1
// depends on lsf_pkg, lsf_line_state, lsf_match, lsf_result_queue
`timescale 1ns / 1ps
`default_nettype none

module line_substring_filter_core import lsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    text_byte_i,
  input  logic                end_of_file_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LineW-1:0]    line_number_o,
  output logic                selected_o,
  output logic                final_line_o
);

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q;
  logic [PatLenW-1:0]  pat_len_q;
  logic                icase_q, invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= PatLenW'(1);
      icase_q   <= 1'b0;
      invert_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[PatLenW-1:0];
        CFG_ICASE:   icase_q   <= cfg_data_i[0];
        CFG_INVERT:  invert_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cfg_t                  cfg;
  logic [2*CfgDataW-1:0] pat_all;

  assign pat_all = {pat_hi_q, pat_lo_q};

  // clamp length to 1..PatternMax
  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      cfg.pattern[j] = pat_all[j*ByteW +: ByteW];
    end
    if (pat_len_q == '0) begin
      cfg.len_m1 = '0;
    end else if (pat_len_q > PatLenW'(PatternMax)) begin
      cfg.len_m1 = LenIdxW'(PatternMax - 1);
    end else begin
      cfg.len_m1 = LenIdxW'(pat_len_q - PatLenW'(1));
    end
    cfg.icase  = icase_q;
    cfg.invert = invert_q;
  end

  logic    accept, push, q_full, pop;
  result_t result, head;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  lsf_line_state u_line_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_file_i (end_of_file_i),
    .cfg_i         (cfg),
    .push_o        (push),
    .result_o      (result)
  );

  lsf_result_queue u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .full_o  (q_full),
    .data_o  (head)
  );

  assign line_number_o = head.line_number;
  assign selected_o    = head.selected;
  assign final_line_o  = head.final_line;

endmodule

`default_nettype wire

/* design/lsf_checker.sv */
// lsf_checker: port-level checks on the line substring filter, bound to the top
// depends on lsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsf_checker import lsf_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             end_of_file_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [LineW-1:0] line_number_o,
  input wire logic             selected_o,
  input wire logic             final_line_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_number_o) &&
      $stable(selected_o) && $stable(final_line_o))
    else $error("lsf: stalled result changed");

  // input only backs up when results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("lsf: input stalled with no pending result");

  // line numbers count from one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != '0)
    else $error("lsf: zero line number");

  // end of file into an empty queue shows up next cycle as the final line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_file_i && !out_valid_o |=>
      out_valid_o && final_line_o)
    else $error("lsf: end of file beat gave no final result");

endmodule

bind line_substring_filter_core lsf_checker u_lsf_checker (.*);

`default_nettype wire

/* tb/line_substring_filter_core_tb.sv */
// line_substring_filter_core_tb: self-checking bench for the fixed-string line filter
// drives text beats with random gaps and checks every line result against a local model
// depends on lsf_pkg and line_substring_filter_core
`timescale 1ns / 1ps

module line_substring_filter_core_tb;
  import lsf_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    text_byte_i;
  logic                end_of_file_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [LineW-1:0]    line_number_o;
  logic                selected_o;
  logic                final_line_o;

  line_substring_filter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_number_o (line_number_o),
    .selected_o    (selected_o),
    .final_line_o  (final_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror
  logic [63:0]        cfg_pat_lo;
  logic [63:0]        cfg_pat_hi;
  logic [PatLenW-1:0] cfg_pat_len;
  logic               cfg_icase;
  logic               cfg_invert;

  // line tracking state, newest byte in line_tail[0]
  logic [ByteW-1:0] line_tail [PatternMax];
  int unsigned      line_col;
  bit               line_hit;
  int unsigned      line_count;

  result_t pending_line_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int bytes_sent;
  int lines_predicted;
  int lines_checked;

  function automatic logic [ByteW-1:0] pattern_byte(input int i);
    if (i < 8) return cfg_pat_lo[i*8 +: 8];
    return cfg_pat_hi[(i-8)*8 +: 8];
  endfunction

  function automatic int used_pattern_len();
    if (cfg_pat_len == 0) return 1;
    if (cfg_pat_len > PatternMax) return PatternMax;
    return cfg_pat_len;
  endfunction

  function automatic logic [ByteW-1:0] case_folded(input logic [ByteW-1:0] c);
    if (cfg_icase && c >= UpperA && c <= UpperZ) return c + CaseDelta;
    return c;
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < PatternMax; i++) line_tail[i] = '0;
    line_col = 0;
    line_hit = 1'b0;
  endfunction

  // one accepted text beat; queues the line result when a line closes
  function automatic void filter_text_byte(input logic [ByteW-1:0] b, input logic eof);
    int      len;
    bit      hit;
    result_t r;
    if (b != Newline) begin
      if (line_col < LineLimit) begin
        len = used_pattern_len();
        for (int i = PatternMax - 1; i > 0; i--) line_tail[i] = line_tail[i-1];
        line_tail[0] = b;
        line_col++;
        if (line_col >= len) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (case_folded(pattern_byte(i)) != case_folded(line_tail[len-1-i])) hit = 1'b0;
          end
          if (hit) line_hit = 1'b1;
        end
      end
      if (!eof) return;
    end
    r.line_number = line_count[LineW-1:0];
    r.selected    = cfg_invert ? !line_hit : line_hit;
    r.final_line  = eof;
    pending_line_results.push_back(r);
    lines_predicted++;
    clear_line();
    if (eof) line_count = 1;
    else if (line_count < 65535) line_count++;
  endfunction

  // receiver side
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void compare_field(input string name, input logic [LineW-1:0] want,
                                        input logic [LineW-1:0] got);
    if (got !== want) begin
      if (err_count < 20)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_line_results.size() == 0) begin
        if (err_count < 20)
          $display("%0t ns: unexpected result, expected none, actual line %0d sel %0b final %0b",
                   $time, line_number_o, selected_o, final_line_o);
        err_count++;
      end else begin
        want = pending_line_results.pop_front();
        lines_checked++;
        compare_field("line_number", want.line_number, line_number_o);
        compare_field("selected", LineW'(want.selected), LineW'(selected_o));
        compare_field("final_line", LineW'(want.final_line), LineW'(final_line_o));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i    = 1'b1;
    text_byte_i   = b;
    end_of_file_i = eof;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_text_byte(b, eof);
    bytes_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_text(input string s, input bit eof_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eof_last && (i == s.len() - 1));
  endtask

  // waits for all results back, then for a line still in the block
  task automatic wait_idle();
    while (pending_line_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    case (idx)
      CFG_PAT_LO:  cfg_pat_lo  = value;
      CFG_PAT_HI:  cfg_pat_hi  = value;
      CFG_PAT_LEN: cfg_pat_len = value[PatLenW-1:0];
      CFG_ICASE:   cfg_icase   = value[0];
      CFG_INVERT:  cfg_invert  = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_pattern(input string p, input logic [PatLenW-1:0] len_reg);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < p.len() && i < PatternMax; i++) begin
      if (i < 8) lo[i*8 +: 8] = p[i];
      else hi[(i-8)*8 +: 8] = p[i];
    end
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_PAT_LEN, 64'(len_reg));
  endtask

  // letters around the fold boundaries plus any byte now and then
  function automatic logic [ByteW-1:0] random_text_byte();
    string letters = "aAbBzZ@[`{";
    if ($urandom_range(3) == 0) return ByteW'($urandom_range(255));
    return letters[$urandom_range(letters.len() - 1)];
  endfunction

  task automatic randomize_options();
    logic [63:0]        words [2];
    int                 plen;
    logic [PatLenW-1:0] len_reg;
    wait_idle();
    case ($urandom_range(7))
      0:       plen = PatternMax;
      1:       plen = $urandom_range(1, PatternMax);
      default: plen = $urandom_range(1, 4);
    endcase
    words[0] = '0;
    words[1] = '0;
    case ($urandom_range(7))
      0: begin
        words[0] = '1;
        words[1] = '1;
      end
      1: ;
      default: begin
        for (int i = 0; i < 8; i++) begin
          words[0][i*8 +: 8] = random_text_byte();
          words[1][i*8 +: 8] = random_text_byte();
        end
      end
    endcase
    len_reg = PatLenW'(plen);
    if (plen == 1 && $urandom_range(1)) len_reg = '0;
    if (plen == PatternMax && $urandom_range(1)) len_reg = PatLenW'($urandom_range(17, 31));
    write_reg(CFG_PAT_LO, words[0]);
    write_reg(CFG_PAT_HI, words[1]);
    write_reg(CFG_PAT_LEN, 64'(len_reg));
    write_reg(CFG_ICASE, 64'($urandom_range(1)));
    write_reg(CFG_INVERT, 64'($urandom_range(1)));
  endtask

  // random line, often with the pattern planted in it
  task automatic send_random_line();
    int               line_len;
    int               insert_at;
    int               plen;
    logic [ByteW-1:0] b;
    line_len  = ($urandom_range(39) == 0) ? $urandom_range(240, 270) : $urandom_range(0, 16);
    insert_at = $urandom_range(1) ? $urandom_range(0, line_len) : -1;
    plen      = used_pattern_len();
    for (int i = 0; i <= line_len; i++) begin
      if (i == insert_at) begin
        for (int j = 0; j < plen; j++) begin
          b = pattern_byte(j);
          if (cfg_icase && $urandom_range(1) && (b | CaseDelta) >= (UpperA | CaseDelta) &&
              (b | CaseDelta) <= (UpperZ | CaseDelta))
            b = b ^ CaseDelta;
          send_byte(b, 1'b0);
        end
      end
      if (i < line_len) send_byte(random_text_byte(), 1'b0);
    end
    case ($urandom_range(9))
      8: send_byte(Newline, 1'b1);
      9: begin
        b = random_text_byte();
        if (b == Newline) b = 8'h00;
        send_byte(b, 1'b1);
      end
      default: send_byte(Newline, 1'b0);
    endcase
  endtask

  // reset pattern is one zero byte: zero is ordinary text
  task automatic test_reset_values();
    send_byte(8'h00, 1'b0);
    send_byte(Newline, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_options();
    wait_idle();
    load_pattern("aB", PatLenW'(2));
    write_reg(CFG_ICASE, 64'd1);
    send_text("xAb\n", 1'b0);
    wait_idle();
    write_reg(CFG_ICASE, 64'd0);
    send_text("xA", 1'b0);
    // fold turned on mid-line, the next compare must use it
    wait_idle();
    write_reg(CFG_ICASE, 64'd1);
    send_text("b\n", 1'b0);
    wait_idle();
    write_reg(CFG_ICASE, 64'd0);
    send_text("xAb", 1'b0);
    wait_idle();
    write_reg(CFG_INVERT, 64'd1);
    send_text("\n", 1'b1);
    // length zero acts as one
    wait_idle();
    load_pattern("q", PatLenW'(0));
    send_text("zq\n", 1'b0);
    send_text("zz", 1'b1);
  endtask

  // all 16 bytes in use, length register above the maximum
  task automatic test_full_length_pattern();
    wait_idle();
    write_reg(CFG_PAT_LO, '1);
    write_reg(CFG_PAT_HI, '1);
    write_reg(CFG_PAT_LEN, 64'd31);
    write_reg(CFG_ICASE, 64'd1);
    write_reg(CFG_INVERT, 64'd1);
    repeat (PatternMax) send_byte(8'hFF, 1'b0);
    send_byte(Newline, 1'b0);
  endtask

  // match must end within the first LineLimit bytes
  task automatic test_long_lines();
    wait_idle();
    load_pattern("wxyz", PatLenW'(4));
    write_reg(CFG_ICASE, 64'd0);
    write_reg(CFG_INVERT, 64'd0);
    repeat (LineLimit - 4) send_byte("a", 1'b0);
    send_text("wxyz\n", 1'b0);
    repeat (LineLimit - 3) send_byte("a", 1'b0);
    send_text("wxyz\n", 1'b1);
  endtask

  task automatic run_random_files();
    int first_bytes;
    int first_lines;
    for (int k = 0; k < 2; k++) begin
      randomize_options();
      first_bytes = bytes_sent;
      first_lines = lines_predicted;
      do send_random_line();
      while (bytes_sent - first_bytes < 24 || lines_predicted - first_lines < 3);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PAT_LO;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    text_byte_i   = '0;
    end_of_file_i = 1'b0;
    cfg_pat_lo    = '0;
    cfg_pat_hi    = '0;
    cfg_pat_len   = PatLenW'(1);
    cfg_icase     = 1'b0;
    cfg_invert    = 1'b0;
    clear_line();
    line_count      = 1;
    err_count       = 0;
    bytes_sent      = 0;
    lines_predicted = 0;
    lines_checked   = 0;
    send_idle_pct   = 35;
    recv_idle_pct   = 81;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_options();
    test_full_length_pattern();
    test_long_lines();
    run_random_files();

    send_idle_pct = 81;
    recv_idle_pct = 35;
    run_random_files();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_files();

    while (pending_line_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("sent %0d text beats, checked %0d line results", bytes_sent, lines_checked);
    $display("(options, line limit edges, random files under three stall mixes)");
    if (err_count == 0 && pending_line_results.size() == 0) begin
      $display("line_substring_filter_core verification clean");
    end else begin
      $display("line_substring_filter_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d line results outstanding", pending_line_results.size());
    $display("line_substring_filter_core verification failed");
    $finish;
  end

endmodule
